>>> hdl/cwl_pkg.sv
`default_nettype none

package cwl_pkg;

   localparam int PORT_W = 16;
   localparam int HOST_W = 48;
   localparam int SLOT_W = 4;

   // Operation carried in the request tuser.
   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_LOOKUP = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Cost of the best match so far before any entry has matched.
   localparam logic [1:0] NO_MATCH_COST = 2'd3;

   typedef struct packed {
      func_type            func;
      logic [PORT_W-1:0]   local_port;
      logic [HOST_W-1:0]   local_host;
      logic [HOST_W-1:0]   foreign_host;
      logic [PORT_W-1:0]   foreign_port;
      logic                allow_wildcard;
   } query_type;

   // Record that walks the row of cells.
   typedef struct packed {
      logic       valid;
      query_type  q;
      logic       taken;
      logic [1:0] cost;
   } carry_type;

   // Remove command broadcast to every cell.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
   } rm_type;

   // Result item; status sits in the lowest bits.
   typedef struct packed {
      logic              wild_score;
      logic [SLOT_W-1:0] slot_out;
      logic              found;
      status_type        status;
   } rsp_type;

endpackage

`default_nettype wire

>>> hdl/cwl_cell.sv
`default_nettype none

module cwl_cell import cwl_pkg::*; #(
   parameter int INDEX = 0,
   parameter int IDX_W = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire carry_type        carry_i,
   input  wire logic [IDX_W-1:0] rank_i,
   input  wire logic [IDX_W-1:0] slot_i,
   output carry_type             carry_o,
   output logic      [IDX_W-1:0] rank_o,
   output logic      [IDX_W-1:0] slot_o,
   input  wire rm_type           rm_i,
   input  wire logic [IDX_W-1:0] gone_rank_i,
   output logic                  valid_o,
   output logic      [IDX_W-1:0] rank_state_o,
   output logic                  hit_o
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam bit REACHABLE = (INDEX < (1 << SLOT_W));

   logic              valid_ff, valid_in;
   logic [IDX_W-1:0]  rank_ff, rank_in;
   logic [PORT_W-1:0] lport_ff;
   logic [HOST_W-1:0] lhost_ff;
   logic [HOST_W-1:0] fhost_ff;
   logic [PORT_W-1:0] fport_ff;
   logic              write_en;

   carry_type         carry_ff, carry_in;
   logic [IDX_W-1:0]  brank_ff, brank_in;
   logic [IDX_W-1:0]  bslot_ff, bslot_in;

   logic              wild;
   logic              skip;
   logic              better;

   assign hit_o        = REACHABLE && (rm_i.slot == SLOT_W'(INDEX));
   assign valid_o      = valid_ff;
   assign rank_state_o = rank_ff;
   assign carry_o      = carry_ff;
   assign rank_o       = brank_ff;
   assign slot_o       = bslot_ff;

   // Wildcard score of this entry against the passing query.
   always_comb begin
      wild = 1'b0;
      skip = (lport_ff != carry_i.q.local_port);
      if (fhost_ff == '0) begin
         wild = (carry_i.q.foreign_host != '0) && (lhost_ff != carry_i.q.local_host);
      end else if (carry_i.q.foreign_host == '0) begin
         wild = 1'b1;
      end else begin
         if (fhost_ff != carry_i.q.foreign_host) begin
            skip = 1'b1;
         end
         if (fport_ff != carry_i.q.foreign_port) begin
            if (fport_ff != '0) begin
               skip = 1'b1;
            end else begin
               wild = 1'b1;
            end
         end
      end
      if (wild && !carry_i.q.allow_wildcard) begin
         skip = 1'b1;
      end
      better = ({1'b0, wild} < carry_i.cost) ||
               (({1'b0, wild} == carry_i.cost) && (rank_ff < rank_i));
   end

   always_comb begin
      valid_in = valid_ff;
      rank_in  = rank_ff;
      write_en = 1'b0;
      carry_in = carry_i;
      brank_in = rank_i;
      bslot_in = slot_i;
      if (rm_i.en) begin
         if (hit_o) begin
            valid_in = 1'b0;
         end else if (valid_ff && (rank_ff > gone_rank_i)) begin
            rank_in = rank_ff - 1'b1;
         end
      end
      if (carry_i.valid) begin
         case (carry_i.q.func)
            FUNC_INSERT: begin
               if (!carry_i.taken && !valid_ff) begin
                  valid_in       = 1'b1;
                  rank_in        = '0;
                  write_en       = 1'b1;
                  carry_in.taken = 1'b1;
                  bslot_in       = MY_IDX;
               end else if (valid_ff) begin
                  rank_in = rank_ff + 1'b1;
               end
            end
            FUNC_LOOKUP: begin
               if (valid_ff && !skip && better) begin
                  carry_in.cost = {1'b0, wild};
                  brank_in      = rank_ff;
                  bslot_in      = MY_IDX;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rank_ff  <= rank_in;
      brank_ff <= brank_in;
      bslot_ff <= bslot_in;
      if (write_en) begin
         lport_ff <= carry_i.q.local_port;
         lhost_ff <= carry_i.q.local_host;
         fhost_ff <= carry_i.q.foreign_host;
         fport_ff <= carry_i.q.foreign_port;
      end
      if (reset) begin
         valid_ff       <= 1'b0;
         carry_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         carry_ff <= carry_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/connection_wildcard_lookup_table.sv
// Insert and lookup walk the row of cells, one cell per cycle, and the result
// is registered once the record leaves the last cell. Remove, a full-table
// insert and the unused code skip the walk and go straight to the result. No
// new request is taken until the previous result has entered the output register.
// Synchronous active-high reset empties the table and clears both channels;
// entry contents are not cleared.
`default_nettype none

module connection_wildcard_lookup_table import cwl_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Request channel.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // Fields from bit 0: slot[3:0], local_port[19:4], local_host[67:20],
   // foreign_host[115:68], foreign_port[131:116], allow_wildcard[132], zero pad.
   input  wire logic [135:0] req_tdata,
   // Fields from bit 0: func[1:0].
   input  wire logic [1:0]   req_tuser,
   // Result channel.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // Fields from bit 0: status[1:0], found[2], slot_out[6:3], wild_score[7].
   output logic [7:0]        rsp_tdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   // The chain of cells. Position k feeds cell k; the last position is the
   // finished record.
   carry_type        chain_carry [ENTRIES+1];
   logic [IDX_W-1:0] chain_rank  [ENTRIES+1];
   logic [IDX_W-1:0] chain_slot  [ENTRIES+1];

   logic             cell_valid  [ENTRIES];
   logic [IDX_W-1:0] cell_rank   [ENTRIES];
   logic             cell_hit    [ENTRIES];

   state_type        state_ff, state_in;
   carry_type        head_ff, head_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] count_ff, count_in;

   rm_type           rm;
   logic             req_fire;
   func_type         req_func;
   query_type        req_q;
   logic [3:0]       req_slot;
   logic             table_full;
   logic             tgt_valid;
   logic [IDX_W-1:0] gone_rank;
   logic             out_free;
   carry_type        tail;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign table_full = (count_ff == CNT_W'(ENTRIES));
   assign tail       = chain_carry[ENTRIES];

   // Unpack the request transfer.
   assign req_func             = func_type'(req_tuser);
   assign req_slot             = req_tdata[3:0];
   assign req_q.func           = req_func;
   assign req_q.local_port     = req_tdata[19:4];
   assign req_q.local_host     = req_tdata[67:20];
   assign req_q.foreign_host   = req_tdata[115:68];
   assign req_q.foreign_port   = req_tdata[131:116];
   assign req_q.allow_wildcard = req_tdata[132];

   assign chain_carry[0] = head_ff;
   assign chain_rank[0]  = '0;
   assign chain_slot[0]  = '0;

   // Remove needs the validity and recency rank of the addressed slot; exactly
   // one cell at most claims the slot, so an AND-OR select is enough.
   always_comb begin
      tgt_valid = 1'b0;
      gone_rank = '0;
      for (int k = 0; k < ENTRIES; k++) begin
         if (cell_hit[k]) begin
            tgt_valid = tgt_valid | cell_valid[k];
            gone_rank = gone_rank | cell_rank[k];
         end
      end
   end

   assign rm.en   = req_fire && (req_func == FUNC_REMOVE) && tgt_valid;
   assign rm.slot = req_slot;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
      cwl_cell #(
         .INDEX (k),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .carry_i      (chain_carry[k]),
         .rank_i       (chain_rank[k]),
         .slot_i       (chain_slot[k]),
         .carry_o      (chain_carry[k+1]),
         .rank_o       (chain_rank[k+1]),
         .slot_o       (chain_slot[k+1]),
         .rm_i         (rm),
         .gone_rank_i  (gone_rank),
         .valid_o      (cell_valid[k]),
         .rank_state_o (cell_rank[k]),
         .hit_o        (cell_hit[k])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if ((req_func == FUNC_LOOKUP) ||
                   ((req_func == FUNC_INSERT) && !table_full)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (tail.valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      head_in       = '0;
      head_in.q     = req_q;
      head_in.cost  = NO_MATCH_COST;
      head_in.valid = req_fire && ((req_func == FUNC_LOOKUP) ||
                                   ((req_func == FUNC_INSERT) && !table_full));

      count_in = count_ff;
      if (head_in.valid && (req_func == FUNC_INSERT)) begin
         count_in = count_ff + 1'b1;
      end else if (rm.en) begin
         count_in = count_ff - 1'b1;
      end

      res_in = res_ff;
      if ((state_ff == ST_IDLE) && req_fire) begin
         res_in = '0;
         case (req_func)
            FUNC_INSERT: begin
               if (table_full) begin
                  res_in.status = STATUS_FULL;
               end
            end
            FUNC_REMOVE: begin
               if (!tgt_valid) begin
                  res_in.status = STATUS_EMPTY;
               end
            end
            default: begin
            end
         endcase
      end else if ((state_ff == ST_SCAN) && tail.valid) begin
         res_in = '0;
         if (tail.q.func == FUNC_INSERT) begin
            res_in.slot_out = SLOT_W'(chain_slot[ENTRIES]);
         end else if (tail.cost != NO_MATCH_COST) begin
            res_in.found      = 1'b1;
            res_in.slot_out   = SLOT_W'(chain_slot[ENTRIES]);
            res_in.wild_score = tail.cost[0];
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/cwl_checker.sv
`default_nettype none

module cwl_checker import cwl_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // Requests taken whose result has not yet been transferred.
   logic [1:0] pend_ff, pend_in;

   always_comb begin
      pend_in = pend_ff;
      if ((req_tvalid && req_tready) && !(rsp_tvalid && rsp_tready)) begin
         pend_in = pend_ff + 1'b1;
      end else if (!(req_tvalid && req_tready) && (rsp_tvalid && rsp_tready)) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("result without a request");

   a_two_deep: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_tready)
      else $error("request taken with two results outstanding");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] <= STATUS_EMPTY)
      else $error("reserved status code");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] == STATUS_OK)
      else $error("found with error status");

endmodule

bind connection_wildcard_lookup_table cwl_checker u_cwl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the connection wildcard lookup table. A short
// directed sequence walks the scoring rules, the unused operation code and
// removal of free slots. It is followed by phases of random requests that fill
// and drain the table, so that inserts into a full table are covered too. Most
// lookups are built from live entries, so that hosts and ports collide often.
// The bench closes with a long hold-off on the result side, which backs the
// block up onto its request channel. Every accepted request is run through a
// model of the table at the moment of its transfer. Each result transfer is
// compared with the oldest prediction still waiting.
module testbench import cwl_pkg::*; ();

   localparam int TABLE_DEPTH     = 16;
   localparam int IDLE_PERCENT    = 12;
   localparam int RANDOM_ITEMS    = 1400;
   localparam int PHASE_ITEMS     = 100;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 400000;
   // Allowance for a full scan through every cell, with a little to spare.
   localparam int SCAN_LATENCY    = TABLE_DEPTH + 3;
   // The request tuser is two bits wide, so this code can be sent as well.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [HOST_W-1:0] ONES_HOST = {HOST_W{1'b1}};
   localparam logic [PORT_W-1:0] ONES_PORT = {PORT_W{1'b1}};

   typedef struct {
      logic [1:0]        func;
      logic [SLOT_W-1:0] slot;
      logic [PORT_W-1:0] local_port;
      logic [HOST_W-1:0] local_host;
      logic [HOST_W-1:0] foreign_host;
      logic [PORT_W-1:0] foreign_port;
      logic              allow_wildcard;
   } request_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [7:0]   rsp_tdata;

   // Model of the connection table. The age is 0 for the newest live entry.
   logic              conn_valid        [TABLE_DEPTH];
   logic [PORT_W-1:0] conn_local_port   [TABLE_DEPTH];
   logic [HOST_W-1:0] conn_local_host   [TABLE_DEPTH];
   logic [HOST_W-1:0] conn_foreign_host [TABLE_DEPTH];
   logic [PORT_W-1:0] conn_foreign_port [TABLE_DEPTH];
   int unsigned       conn_age          [TABLE_DEPTH];

   // Predicted results, oldest first.
   rsp_type           pending_results [$];

   // Small pools of ports and hosts, so that random traffic finds matches.
   logic [PORT_W-1:0] port_pool [4];
   logic [HOST_W-1:0] host_pool [4];

   logic idle_enabled;
   logic hold_off_pending;
   int   failures;
   int   cycle_count;

   connection_wildcard_lookup_table #(
      .ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Applies one request to the table model and returns the result that the
   // block must give for it.
   function automatic rsp_type apply_request(input request_type r);
      rsp_type     res;
      int          i;
      int          free_slot;
      int unsigned gone;
      logic [1:0]  best_cost;
      int unsigned best_age;
      int          best_slot;
      logic [1:0]  wild;
      res        = '0;
      res.status = STATUS_OK;
      case (r.func)
         FUNC_INSERT: begin
            free_slot = -1;
            for (i = 0; i < TABLE_DEPTH; i++)
               if (!conn_valid[i] && free_slot < 0)
                  free_slot = i;
            if (free_slot < 0) begin
               res.status = STATUS_FULL;
            end else begin
               for (i = 0; i < TABLE_DEPTH; i++)
                  if (conn_valid[i])
                     conn_age[i]++;
               conn_valid[free_slot]        = 1'b1;
               conn_local_port[free_slot]   = r.local_port;
               conn_local_host[free_slot]   = r.local_host;
               conn_foreign_host[free_slot] = r.foreign_host;
               conn_foreign_port[free_slot] = r.foreign_port;
               conn_age[free_slot]          = 0;
               res.slot_out                 = free_slot[SLOT_W-1:0];
            end
         end
         FUNC_REMOVE: begin
            if (int'(r.slot) >= TABLE_DEPTH || !conn_valid[r.slot]) begin
               res.status = STATUS_EMPTY;
            end else begin
               gone               = conn_age[r.slot];
               conn_valid[r.slot] = 1'b0;
               // Entries older than the one removed each move one step newer.
               for (i = 0; i < TABLE_DEPTH; i++)
                  if (conn_valid[i] && conn_age[i] > gone)
                     conn_age[i]--;
            end
         end
         FUNC_LOOKUP: begin
            best_cost = NO_MATCH_COST;
            best_age  = 0;
            best_slot = 0;
            for (i = 0; i < TABLE_DEPTH; i++) begin
               if (!conn_valid[i] || conn_local_port[i] != r.local_port)
                  continue;
               wild = 2'd0;
               if (conn_foreign_host[i] == '0) begin
                  // Bound but not connected: a wildcard when the local host
                  // differs and the query names a peer.
                  if (r.foreign_host != '0 && conn_local_host[i] != r.local_host)
                     wild = 2'd1;
               end else if (r.foreign_host == '0) begin
                  wild = 2'd1;
               end else begin
                  if (conn_foreign_host[i] != r.foreign_host)
                     continue;
                  if (conn_foreign_port[i] != r.foreign_port) begin
                     if (conn_foreign_port[i] != '0)
                        continue;
                     wild = 2'd1;
                  end
               end
               if (wild != 2'd0 && !r.allow_wildcard)
                  continue;
               if (wild < best_cost || (wild == best_cost && conn_age[i] < best_age)) begin
                  best_cost = wild;
                  best_age  = conn_age[i];
                  best_slot = i;
               end
            end
            if (best_cost != NO_MATCH_COST) begin
               res.found      = 1'b1;
               res.slot_out   = best_slot[SLOT_W-1:0];
               res.wild_score = best_cost[0];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic logic [HOST_W-1:0] random_host();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[HOST_W-1:0];
   endfunction

   function automatic logic [PORT_W-1:0] pick_port();
      logic [31:0] raw;
      raw = $urandom;
      if ($urandom_range(99) < 90)
         return port_pool[$urandom_range(3)];
      return raw[PORT_W-1:0];
   endfunction

   function automatic logic [HOST_W-1:0] pick_host();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 25)
         return '0;
      if (roll < 90)
         return host_pool[$urandom_range(3)];
      return random_host();
   endfunction

   // Builds one random request. Removes mostly name live slots, and lookups
   // mostly start from a live entry and then vary the peer and local host.
   function automatic request_type random_request(input int insert_pct, input int remove_pct);
      request_type r;
      int          i;
      int          pick;
      int unsigned roll;
      int          live [$];
      logic [31:0] raw;
      for (i = 0; i < TABLE_DEPTH; i++)
         if (conn_valid[i])
            live.push_back(i);
      raw              = $urandom;
      r.slot           = raw[SLOT_W-1:0];
      r.local_port     = pick_port();
      r.local_host     = pick_host();
      r.foreign_host   = pick_host();
      r.foreign_port   = pick_port();
      r.allow_wildcard = raw[31];
      roll = $urandom_range(99);
      if (roll < 2) begin
         r.func = FUNC_UNUSED;
      end else if (roll < 2 + insert_pct) begin
         r.func = FUNC_INSERT;
      end else if (roll < 2 + insert_pct + remove_pct) begin
         r.func = FUNC_REMOVE;
         if (live.size() != 0 && $urandom_range(99) < 80)
            r.slot = SLOT_W'(live[$urandom_range(live.size() - 1)]);
      end else begin
         r.func = FUNC_LOOKUP;
         if (live.size() != 0 && $urandom_range(99) < 85) begin
            pick         = live[$urandom_range(live.size() - 1)];
            r.local_port = conn_local_port[pick];
            if ($urandom_range(1))
               r.local_host = conn_local_host[pick];
            case ($urandom_range(3))
               0, 1: r.foreign_host = conn_foreign_host[pick];
               2:    r.foreign_host = '0;
               default: ;
            endcase
            if ($urandom_range(1))
               r.foreign_port = conn_foreign_port[pick];
         end
      end
      return r;
   endfunction

   // Offers one request and returns once its transfer has taken place. The
   // valid stays high afterwards, so back-to-back requests need no gap.
   task automatic send_request(input request_type r);
      @(negedge clock);
      while (idle_enabled && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = r.func;
      req_tdata  = {3'b000, r.allow_wildcard, r.foreign_port, r.foreign_host,
                    r.local_host, r.local_port, r.slot};
      do
         @(posedge clock);
      while (!req_tready);
      pending_results.push_back(apply_request(r));
   endtask

   task automatic send_fields(input logic [1:0] func, input logic [SLOT_W-1:0] slot,
                              input logic [PORT_W-1:0] lport,
                              input logic [HOST_W-1:0] lhost,
                              input logic [HOST_W-1:0] fhost,
                              input logic [PORT_W-1:0] fport, input logic allow);
      request_type r;
      r.func           = func;
      r.slot           = slot;
      r.local_port     = lport;
      r.local_host     = lhost;
      r.foreign_host   = fhost;
      r.foreign_port   = fport;
      r.allow_wildcard = allow;
      send_request(r);
   endtask

   task automatic test_directed();
      // Nothing can be found or removed in an empty table, and the unused
      // code must leave everything as it is.
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, ONES_HOST, ONES_HOST, ONES_PORT, 1'b1);
      send_fields(FUNC_REMOVE, 4'hF, '0, '0, '0, '0, 1'b0);
      send_fields(FUNC_UNUSED, 4'hF, ONES_PORT, ONES_HOST, ONES_HOST, ONES_PORT, 1'b1);
      // Slot 0 is bound only, slot 1 is fully connected, slot 2 is connected
      // to any peer port and slot 3 sits on local port zero.
      send_fields(FUNC_INSERT, 4'h0, ONES_PORT, ONES_HOST, '0, '0, 1'b0);
      send_fields(FUNC_INSERT, 4'h0, ONES_PORT, 48'h1, ONES_HOST, ONES_PORT, 1'b0);
      send_fields(FUNC_INSERT, 4'h0, ONES_PORT, 48'h1, ONES_HOST, '0, 1'b0);
      send_fields(FUNC_INSERT, 4'hF, '0, '0, '0, '0, 1'b1);
      // An exact connected match, then an exact match on the bound entry.
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, 48'h1, ONES_HOST, ONES_PORT, 1'b0);
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, ONES_HOST, ONES_HOST, 16'h1234, 1'b0);
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, ONES_HOST, ONES_HOST, 16'h1234, 1'b1);
      // Only wildcard candidates: refused without permission, then the newest
      // of them wins.
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, 48'h5, ONES_HOST, 16'h1234, 1'b0);
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, 48'h5, ONES_HOST, 16'h1234, 1'b1);
      // A query without a peer, and one whose peer host matches no entry.
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, 48'h5, '0, '0, 1'b0);
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, 48'h5, '0, '0, 1'b1);
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, ONES_HOST, 48'h2, ONES_PORT, 1'b1);
      send_fields(FUNC_LOOKUP, 4'h0, '0, '0, '0, '0, 1'b0);
      send_fields(FUNC_LOOKUP, 4'h0, 16'h7FFF, ONES_HOST, ONES_HOST, ONES_PORT, 1'b1);
      // A duplicate entry is accepted, and the newer copy wins the tie.
      send_fields(FUNC_INSERT, 4'h0, ONES_PORT, 48'h1, ONES_HOST, ONES_PORT, 1'b0);
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, 48'h1, ONES_HOST, ONES_PORT, 1'b0);
      // Freeing a slot twice, then refilling the lowest hole.
      send_fields(FUNC_REMOVE, 4'h1, '0, '0, '0, '0, 1'b0);
      send_fields(FUNC_REMOVE, 4'h1, '0, '0, '0, '0, 1'b0);
      send_fields(FUNC_INSERT, 4'h0, 16'h8000, 48'h8000_0000_0000, 48'h8000_0000_0001,
                  16'h8000, 1'b0);
      send_fields(FUNC_LOOKUP, 4'h0, ONES_PORT, 48'h1, ONES_HOST, ONES_PORT, 1'b0);
   endtask

   // Phases that fill, drain and mix, so that the table runs full and empty
   // several times. One phase runs with no idling on either side.
   task automatic test_random();
      int phase;
      int n;
      int insert_pct;
      int remove_pct;
      port_pool[0] = '0;
      for (n = 1; n < 4; n++)
         port_pool[n] = PORT_W'($urandom_range(65535));
      for (n = 0; n < 4; n++)
         host_pool[n] = random_host();
      for (phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
         case (phase % 3)
            0: begin insert_pct = 55; remove_pct = 8;  end
            1: begin insert_pct = 20; remove_pct = 20; end
            default: begin insert_pct = 8; remove_pct = 45; end
         endcase
         idle_enabled = (phase != 4);
         for (n = 0; n < PHASE_ITEMS; n++)
            send_request(random_request(insert_pct, remove_pct));
      end
      idle_enabled = 1'b1;
   endtask

   // The receiver stops taking results for a long stretch while requests keep
   // coming, so that the block has to stall its request channel.
   task automatic test_backpressure();
      int n;
      hold_off_pending = 1'b1;
      for (n = 0; n < 60; n++)
         send_request(random_request(30, 20));
   endtask

   // Result side: ready drops at random, or for a long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready       = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready = !(idle_enabled && $urandom_range(99) < IDLE_PERCENT);
         end
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_type'(rsp_tdata);
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected: tdata %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               failures++;
            end
            if (got.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, got.found);
               failures++;
            end
            if (got.slot_out !== want.slot_out) begin
               $error("slot_out: expected %0d, got %0d", want.slot_out, got.slot_out);
               failures++;
            end
            if (got.wild_score !== want.wild_score) begin
               $error("wild_score: expected %0d, got %0d", want.wild_score, got.wild_score);
               failures++;
            end
         end
      end
   end

   // Guard against a hung block.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("connection_wildcard_lookup_table regression: fail");
         $finish;
      end
   end

   initial begin
      int i;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      req_tuser        = '0;
      idle_enabled     = 1'b1;
      hold_off_pending = 1'b0;
      failures         = 0;
      cycle_count      = 0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         conn_valid[i] = 1'b0;
         conn_age[i]   = 0;
      end
      repeat (11) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random();
      test_backpressure();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      // Any stray result would show up within one scan.
      repeat (SCAN_LATENCY + 5) @(posedge clock);
      if (failures == 0)
         $display("connection_wildcard_lookup_table regression: pass");
      else
         $display("connection_wildcard_lookup_table regression: fail");
      $finish;
   end

endmodule
